// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// Check that a condition implies another one in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/lkvc_pkg.sv -----
// Shared types and constants of the LRU key-value cache.
// Depends on nothing; used by the interfaces and all cache modules.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // Request modes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  // Value returned by a get that misses
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  // Capacity register value after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

endpackage

// ----- rtl/core/lkvc_if.sv -----
// Request and response channel interfaces of the LRU key-value cache.
// Depends on lkvc_pkg for field widths.
`timescale 1ns / 1ps

interface lkvc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [lkvc_pkg::KEY_W-1:0]    lookup_key;
  logic signed [lkvc_pkg::VAL_W-1:0]    write_value;

  modport source (output valid, mode, lookup_key, write_value, input ready);
  modport sink   (input valid, mode, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic signed [lkvc_pkg::VAL_W-1:0]    read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

// ----- rtl/core/lkvc_store.sv -----
// Key and value memories of the LRU key-value cache.
// Depends on lkvc_pkg; one write port and registered reads per memory.
`timescale 1ns / 1ps

module lkvc_store #(
  parameter int ENTRIES = 16,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                              clk,
  input  logic                              key_we,
  input  logic                              val_we,
  input  logic [IDX_W-1:0]                  wr_addr,
  input  logic signed [lkvc_pkg::KEY_W-1:0] wr_key,
  input  logic signed [lkvc_pkg::VAL_W-1:0] wr_val,
  input  logic [IDX_W-1:0]                  key_raddr,
  input  logic [IDX_W-1:0]                  val_raddr,
  output logic signed [lkvc_pkg::KEY_W-1:0] key_rd,
  output logic signed [lkvc_pkg::VAL_W-1:0] val_rd
);

  logic signed [lkvc_pkg::KEY_W-1:0] key_mem [ENTRIES];
  logic signed [lkvc_pkg::VAL_W-1:0] val_mem [ENTRIES];

  // Write and read the key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    key_rd <= key_mem[key_raddr];
  end

  // Write and read the value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    val_rd <= val_mem[val_raddr];
  end

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: sequencer, rank memory, result register.
// Depends on lkvc_pkg, lkvc_if, lkvc_store and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// A request on req carries mode (get or set), lookup_key and write_value.
// It is taken when req.valid and req.ready are high; ready is high only while
// the sequencer is idle and rst is low. Each request yields one response on rsp:
// hit, and read_value (stored value on a get hit, -1 on a get miss, 0 on set).
// Sequence: one compare step per occupied entry scans the keys and ranks, one
// decide step picks the slot, then one rank read-modify-write step per occupied
// entry ages the younger entries; an insert grows occ before the rank pass.
// The single key comparator and the rank memory port make each pass serial.
// A get miss skips the rank pass. ready waits for the idle state, so the next
// request is taken only after the response is loaded into its register.
// cfg_we / cfg_data write the capacity register; write it only while idle.
// Reset empties the table and sets the capacity to 16; no clearing pass runs.
// When rsp is stalled, the finished response waits in its register and the
// next request is still taken; it completes but holds until rsp drains.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lkvc_pkg::CFG_W-1:0]   cfg_data,
  lkvc_req_if.sink                     req,
  lkvc_rsp_if.source                   rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TOUCH,
    ST_DONE
  } state_t;

  state_t                             state;
  logic [lkvc_pkg::CFG_W-1:0]         capacity;
  logic [CNT_W-1:0]                   occ;
  logic [CNT_W-1:0]                   idx;
  logic                               pend;
  logic [IDX_W-1:0]                   tag;

  logic                               req_mode;
  logic signed [lkvc_pkg::KEY_W-1:0]  req_key;
  logic signed [lkvc_pkg::VAL_W-1:0]  req_val;

  logic                               hit_f;
  logic [IDX_W-1:0]                   found;
  logic [IDX_W-1:0]                   found_rank;
  logic [IDX_W-1:0]                   victim;
  logic [IDX_W-1:0]                   worst;
  logic [IDX_W-1:0]                   slot;
  logic [IDX_W-1:0]                   rank_ref;

  logic                               rsp_valid;
  logic                               rsp_hit;
  logic signed [lkvc_pkg::VAL_W-1:0]  rsp_value;

  logic [IDX_W-1:0]                   rank_mem [ENTRIES];
  logic [IDX_W-1:0]                   rank_q;
  logic                               rank_we;
  logic [IDX_W-1:0]                   rank_wdata;

  logic [IDX_W-1:0]                   rd_addr;
  logic                               rd_go;
  logic [CNT_W-1:0]                   cap_eff;
  logic                               full;
  logic                               key_we;
  logic                               val_we;
  logic [IDX_W-1:0]                   wr_addr;
  logic signed [lkvc_pkg::KEY_W-1:0]  key_rd;
  logic signed [lkvc_pkg::VAL_W-1:0]  val_rd;

  // Drive the channel handshakes
  assign req.ready      = (state == ST_IDLE) && !rst;
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;

  // Sweep address shared by the key scan and the rank pass
  assign rd_addr = idx[IDX_W-1:0];
  assign rd_go   = ((state == ST_SCAN) || (state == ST_TOUCH)) && (idx < occ);

  // Clamp the capacity register to 1..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign full = (occ >= cap_eff);

  // On a set, write the value (and the key for a new entry) when the target slot is decided
  assign key_we  = (state == ST_DECIDE) && (req_mode == lkvc_pkg::MODE_SET) && !hit_f;
  assign val_we  = (state == ST_DECIDE) && (req_mode == lkvc_pkg::MODE_SET);
  assign wr_addr = hit_f ? found : (full ? victim : occ[IDX_W-1:0]);

  // Age younger entries, make the touched slot most recent
  assign rank_we = (state == ST_TOUCH) && pend;
  always_comb begin
    if (tag == slot) begin
      rank_wdata = '0;
    end else if (rank_q < rank_ref) begin
      rank_wdata = rank_q + 1'b1;
    end else begin
      rank_wdata = rank_q;
    end
  end

  // Rank memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[tag] <= rank_wdata;
    end
    rank_q <= rank_mem[rd_addr];
  end

  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk       (clk),
    .key_we    (key_we),
    .val_we    (val_we),
    .wr_addr   (wr_addr),
    .wr_key    (req_key),
    .wr_val    (req_val),
    .key_raddr (rd_addr),
    .val_raddr (found),
    .key_rd    (key_rd),
    .val_rd    (val_rd)
  );

  // Sequencer, capacity register and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= lkvc_pkg::CAP_RESET;
      occ       <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (rsp_valid && rsp.ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_mode <= req.mode;
            req_key  <= req.lookup_key;
            req_val  <= req.write_value;
            hit_f    <= 1'b0;
            found    <= '0;
            worst    <= '0;
            victim   <= '0;
            idx      <= '0;
            pend     <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Compare one stored key and track the oldest rank
          pend <= rd_go;
          tag  <= rd_addr;
          if (rd_go) begin
            idx <= idx + 1'b1;
          end
          if (pend) begin
            if (!hit_f && (key_rd == req_key)) begin
              hit_f      <= 1'b1;
              found      <= tag;
              found_rank <= rank_q;
            end
            if (rank_q >= worst) begin
              worst  <= rank_q;
              victim <= tag;
            end
          end
          if (!rd_go && !pend) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          idx  <= '0;
          pend <= 1'b0;
          if ((req_mode == lkvc_pkg::MODE_GET) && !hit_f) begin
            state <= ST_DONE;
          end else begin
            state <= ST_TOUCH;
            if (hit_f) begin
              slot     <= found;
              rank_ref <= found_rank;
            end else if (full) begin
              slot     <= victim;
              rank_ref <= worst;
            end else begin
              slot     <= occ[IDX_W-1:0];
              rank_ref <= occ[IDX_W-1:0];
              occ      <= occ + 1'b1;
            end
          end
        end
        ST_TOUCH: begin
          // Read one rank; the write-back lands in the next cycle
          pend <= rd_go;
          tag  <= rd_addr;
          if (rd_go) begin
            idx <= idx + 1'b1;
          end
          if (!rd_go && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the response register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_hit   <= hit_f;
            if (req_mode == lkvc_pkg::MODE_SET) begin
              rsp_value <= '0;
            end else if (hit_f) begin
              rsp_value <= val_rd;
            end else begin
              rsp_value <= lkvc_pkg::MISS_VALUE;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_occ_bound, clk, rst, occ <= CNT_W'(ENTRIES))
  `ASSERT_NEXT(a_req_starts_scan, clk, rst, req.valid && req.ready, state == ST_SCAN)
  `ASSERT_SAME(a_occ_step, clk, rst, !$past(rst) && (occ != $past(occ)), occ == $past(occ) + 1'b1)
  `ASSERT_SAME(a_rsp_from_done, clk, rst, !$past(rst) && $rose(rsp_valid), $past(state) == ST_DONE)

endmodule

// ----- tb/lkvc_tb_pkg.sv -----
// Scoreboard for the LRU key-value cache testbench: a table model with recency
// ranks that predicts each response, and the queue of responses still owed.
// Depends on lkvc_pkg for field widths, request modes and the miss value.
`timescale 1ns / 1ps

package lkvc_tb_pkg;

  import lkvc_pkg::*;

  localparam int TABLE_DEPTH = 16;

  typedef struct {
    logic                     hit;
    logic signed [VAL_W-1:0]  read_value;
  } lkvc_response_t;

  class lru_cache_model;
    logic [KEY_W-1:0]  slot_key[TABLE_DEPTH];
    logic [VAL_W-1:0]  slot_value[TABLE_DEPTH];
    logic [3:0]        slot_rank[TABLE_DEPTH];
    int unsigned       occupied;
    logic [CFG_W-1:0]  capacity;
    lkvc_response_t    owed_responses[$];
    int                errors;
    int                get_hits;
    int                set_hits;
    int                evictions;

    function new();
      foreach (slot_rank[i]) begin
        slot_key[i] = '0;
        slot_value[i] = '0;
        slot_rank[i] = '0;
      end
      occupied = 0;
      capacity = CAP_RESET;
      errors = 0;
      get_hits = 0;
      set_hits = 0;
      evictions = 0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return owed_responses.size();
    endfunction

    // Make a slot most recent; entries younger than it age by one.
    function void promote(int unsigned slot);
      logic [3:0] old_rank;
      old_rank = slot_rank[slot];
      for (int unsigned i = 0; i < occupied; i++) begin
        if (i != slot && slot_rank[i] < old_rank) slot_rank[i] = slot_rank[i] + 4'd1;
      end
      slot_rank[slot] = '0;
    endfunction

    // Apply one accepted request to the table and queue the response it owes.
    function void note_request(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      int unsigned    slot;
      int unsigned    limit;
      bit             found;
      logic [3:0]     worst;
      lkvc_response_t rsp;
      found = 1'b0;
      slot = 0;
      for (int unsigned i = 0; i < occupied; i++) begin
        if (!found && slot_key[i] == key) begin
          found = 1'b1;
          slot = i;
        end
      end
      rsp.hit = found;
      if (mode == MODE_GET) begin
        if (found) begin
          rsp.read_value = slot_value[slot];
          promote(slot);
          get_hits++;
        end else begin
          rsp.read_value = MISS_VALUE;
        end
      end else begin
        rsp.read_value = '0;
        // Zero capacity acts as one; anything past the table depth saturates.
        limit = (capacity == 0) ? 1 : ((capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity);
        if (found) begin
          slot_value[slot] = value;
          promote(slot);
          set_hits++;
        end else if (occupied >= limit) begin
          // Replace the least recent entry in place; ties go to the higher slot.
          worst = '0;
          for (int unsigned i = 0; i < occupied; i++) begin
            if (slot_rank[i] >= worst) begin
              worst = slot_rank[i];
              slot = i;
            end
          end
          slot_key[slot] = key;
          slot_value[slot] = value;
          promote(slot);
          evictions++;
        end else begin
          slot = occupied;
          slot_key[slot] = key;
          slot_value[slot] = value;
          occupied++;
          slot_rank[slot] = 4'(occupied - 1);
          promote(slot);
        end
      end
      owed_responses.push_back(rsp);
    endfunction

    // Compare one accepted response with the oldest one owed.
    function void check_response(logic hit, logic signed [VAL_W-1:0] read_value);
      lkvc_response_t want;
      if (owed_responses.size() == 0) begin
        $error("unexpected response: hit %0b read_value %0d", hit, read_value);
        errors++;
        return;
      end
      want = owed_responses.pop_front();
      if (hit !== want.hit) begin
        $error("hit mismatch: expected %0b, actual %0b", want.hit, hit);
        errors++;
      end
      if (read_value !== want.read_value) begin
        $error("read_value mismatch: expected %0d, actual %0d", want.read_value, read_value);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/lru_key_value_cache_tb.sv -----
// Top of the LRU key-value cache testbench: clock, reset, request and response drivers.
// Depends on lkvc_pkg, lkvc_if, lkvc_tb_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

  import lkvc_pkg::*;
  import lkvc_tb_pkg::*;

  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 133;
  localparam int SETTLE_TICKS = 60;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  lkvc_req_if req ();
  lkvc_rsp_if rsp ();

  lru_cache_model cache_model;
  bit             tx_steady;
  bit             rx_steady;
  int             requests_sent;
  int             cap_writes;

  lru_key_value_cache #(
    .ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .req     (req),
    .rsp     (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Unless tx_steady is set, hold off a random delay, then present one request until it is taken.
  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= mode;
    req.lookup_key  <= key;
    req.write_value <= value;
    do @(posedge clk); while (!req.ready);
    cache_model.note_request(mode, key, value);
    requests_sent++;
  endtask

  // Drop valid and wait for every owed response, then let the block settle.
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (cache_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cache_model.set_capacity(cap);
    cap_writes++;
  endtask

  // One capacity setting: mostly keys from a small pool so gets and sets hit,
  // with some fresh random keys mixed in.
  task automatic run_phase(input logic [CFG_W-1:0] cap, input bit pause_mid);
    logic [KEY_W-1:0] pool[TABLE_DEPTH + 6];
    int               pool_n;
    int               usable;
    logic [KEY_W-1:0] key;
    logic             mode;
    write_capacity(cap);
    usable = (cap == 0) ? 1 : ((cap > TABLE_DEPTH) ? TABLE_DEPTH : cap);
    pool_n = usable + $urandom_range(1, 6);
    foreach (pool[j]) pool[j] = $urandom;
    case ($urandom_range(0, 4))
      0: pool[0] = 32'h8000_0000;
      1: pool[0] = 32'h7FFF_FFFF;
      2: pool[0] = 32'h0000_0000;
      3: pool[0] = 32'hFFFF_FFFF;
      default: ;
    endcase
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (pause_mid && i == PHASE_ITEMS / 2) wait_idle();
      key  = ($urandom_range(0, 99) < 90) ? pool[$urandom_range(0, pool_n - 1)] : $urandom;
      mode = ($urandom_range(0, 1) == 1) ? MODE_SET : MODE_GET;
      send_request(mode, key, $urandom);
    end
  endtask

  // Response side: random stalls unless rx_steady is set, then take and check one response.
  initial begin : response_drain
    int stall;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      cache_model.check_response(rsp.hit, rsp.read_value);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] cap_plan[PHASES];
    int               directed_count;
    cache_model = new();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    requests_sent = 0;
    cap_writes = 0;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    req.valid       <= 1'b0;
    req.mode        <= MODE_GET;
    req.lookup_key  <= '0;
    req.write_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extreme keys and values, overwrite, misses.
    send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(MODE_SET, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_SET, 32'h0000_0000, 32'h5A5A_A5A5);
    send_request(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(MODE_GET, 32'h0000_3039, 32'h0000_0000);
    send_request(MODE_GET, 32'hFFFF_FFFE, 32'h1234_5678);

    // Capacity dropped below occupancy: a set miss replaces the oldest in place.
    write_capacity(5'd2);
    send_request(MODE_SET, 32'h0000_0007, 32'h0000_0007);
    send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(MODE_SET, 32'h0000_0008, 32'hDEAD_BEEF);
    send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);

    // Capacity zero behaves as one.
    write_capacity(5'd0);
    send_request(MODE_SET, 32'h0000_0009, 32'h0000_0009);
    send_request(MODE_GET, 32'h0000_0009, 32'h0000_0000);
    send_request(MODE_SET, 32'h0000_000A, 32'h0000_000A);
    send_request(MODE_GET, 32'h0000_0009, 32'h0000_0000);

    // Capacity above the table depth saturates.
    write_capacity(5'd31);
    send_request(MODE_SET, 32'h0000_000B, 32'hCAFE_F00D);
    send_request(MODE_GET, 32'h0000_000B, 32'h0000_0000);
    send_request(MODE_GET, 32'h0000_000A, 32'h0000_0000);
    directed_count = requests_sent;

    // Random phases, small capacities first so occupancy grows step by step.
    cap_plan = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd16, 5'd0,
                 5'd17, 5'd31, 5'd4, 5'd16, 5'd1, 5'd12, 5'd16};
    cap_plan[12] = 5'($urandom_range(1, 16));
    for (int p = 0; p < PHASES; p++) begin
      tx_steady = (p % 3 == 2);
      rx_steady = (p % 4 == 3);
      run_phase(cap_plan[p], p % 2 == 1);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    wait_idle();
    repeat (SETTLE_TICKS) @(posedge clk);
    $display("Ran %0d requests (%0d directed) over %0d capacity writes, sizes 0 to 31.",
             requests_sent, directed_count, cap_writes);
    $display("Saw %0d get hits, %0d set hits and %0d evictions.",
             cache_model.get_hits, cache_model.set_hits, cache_model.evictions);
    if (cache_model.errors == 0) begin
      $display("lru_key_value_cache_tb passed");
    end else begin
      $display("lru_key_value_cache_tb failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #20_000_000;
    $display("lru_key_value_cache_tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_if.sv
rtl/core/lkvc_store.sv
rtl/core/lru_key_value_cache.sv
tb/lkvc_tb_pkg.sv
tb/lru_key_value_cache_tb.sv
